### sv/euler_pose_to_matrix_macros.svh
// Assertion macros used by the checker file.
`ifndef EULER_POSE_TO_MATRIX_MACROS_SVH
`define EULER_POSE_TO_MATRIX_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define EPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define EPM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/epm_pkg.sv
// ----------------------------------------------------------------------------
// epm_pkg
// Types, fixed-point constants and the arctangent table for the pose block.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int unsigned AngW = 36;   // Q.30 angle with headroom
  localparam int unsigned CsW  = 34;   // CORDIC x/y width, Q.30 with headroom

  localparam logic signed [AngW-1:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [AngW-1:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [CsW-1:0]  Q30GainInv = 34'sd652032874;
  localparam logic signed [CsW-1:0]  Q30One     = 34'sd1073741824;

  // Named signed element types, so that a selected lane stays signed.
  typedef logic signed [CsW-1:0]  cs_t;
  typedef logic signed [AngW-1:0] ang_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] yaw_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } pose_out_t;

  // Working set of three CORDIC rotators carried down the cell row.
  typedef struct packed {
    cs_t  [2:0]         x;
    cs_t  [2:0]         y;
    ang_t [2:0]         z;
    logic [2:0]         flip;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } cell_t;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    begin
      unique case (i)
        5'd0:  r = 36'sd843314857;
        5'd1:  r = 36'sd497837829;
        5'd2:  r = 36'sd263043837;
        5'd3:  r = 36'sd133525159;
        5'd4:  r = 36'sd67021687;
        5'd5:  r = 36'sd33543516;
        5'd6:  r = 36'sd16775851;
        5'd7:  r = 36'sd8388437;
        5'd8:  r = 36'sd4194283;
        5'd9:  r = 36'sd2097149;
        5'd31: r = 36'sd0;
        default: r = 36'sd1 <<< (5'd30 - i);
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [CsW-1:0] sat_unit(input logic signed [CsW-1:0] v);
    begin
      if (v > Q30One) return Q30One;
      else if (v < -Q30One) return -Q30One;
      else return v;
    end
  endfunction

endpackage

### sv/euler_pose_to_matrix.sv
// ----------------------------------------------------------------------------
// euler_pose_to_matrix
// Camera viewpoint to 3x4 pose: rotation Ry(yaw)*Rx(-pitch)*Rz(roll), Q2.30.
// ----------------------------------------------------------------------------
// The block accepts one viewpoint transaction per cycle and returns one pose
// transaction per viewpoint, in order. The pipeline is CORDIC_STEPS + 6
// registers deep: one register of angle range reduction, one CORDIC cell
// per iteration (each cell rotates the yaw, pitch and roll vectors
// together) and five stages of multiply, round and saturate. The whole
// pipeline advances only when the output register is empty or being drained,
// so a stalled consumer holds all transactions in place and back-pressure
// reaches the input at once.
module euler_pose_to_matrix import epm_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 28
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pose_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pose_out_t out_data_o
);

  logic en;
  // The pipeline moves when the output slot is free or is being taken.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Range reduction of the three angles: Q4.28 times four gives Q.30, then
  // fold into [-pi, pi] and then into [-pi/2, pi/2] with a sign flip.
  cell_t red_d, red_q;
  logic  red_v_q;
  logic signed [AngW-1:0] ang [3];

  always_comb begin
    red_d = '0;
    ang[0] = AngW'(in_data_i.yaw_angle) <<< 2;
    ang[1] = AngW'(in_data_i.pitch_angle) <<< 2;
    ang[2] = AngW'(in_data_i.roll_angle) <<< 2;
    for (int k = 0; k < 3; k++) begin
      if (ang[k] > Q30Pi) ang[k] = ang[k] - Q30TwoPi;
      else if (ang[k] < -Q30Pi) ang[k] = ang[k] + Q30TwoPi;
      red_d.flip[k] = 1'b0;
      if (ang[k] > Q30HalfPi) begin
        ang[k] = ang[k] - Q30Pi;
        red_d.flip[k] = 1'b1;
      end else if (ang[k] < -Q30HalfPi) begin
        ang[k] = ang[k] + Q30Pi;
        red_d.flip[k] = 1'b1;
      end
      red_d.x[k] = Q30GainInv;
      red_d.y[k] = '0;
      red_d.z[k] = ang[k];
    end
    red_d.px = in_data_i.pos_x;
    red_d.py = in_data_i.pos_y;
    red_d.pz = in_data_i.pos_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_v_q <= 1'b0;
    end else if (en) begin
      red_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q <= red_d;
    end
  end

  // Row of CORDIC cells, one per iteration.
  cell_t chain_data [CORDIC_STEPS+1];
  logic  chain_v    [CORDIC_STEPS+1];

  assign chain_data[0] = red_q;
  assign chain_v[0]    = red_v_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    epm_cell #(.Step(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Products, rounding and output register.
  epm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_v[CORDIC_STEPS]),
    .data_i  (chain_data[CORDIC_STEPS]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

### sv/epm_cell.sv
// ----------------------------------------------------------------------------
// epm_cell
// One CORDIC iteration for three angles at once, registered, with a valid bit.
// ----------------------------------------------------------------------------
module epm_cell import epm_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cell_t data_i,
  output logic  valid_o,
  output cell_t data_o
);

  localparam logic [4:0] StepIdx = 5'(Step);

  cell_t data_d, data_q;
  logic  valid_q;

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      if (!data_i.z[k][AngW-1]) begin
        data_d.x[k] = data_i.x[k] - (data_i.y[k] >>> Step);
        data_d.y[k] = data_i.y[k] + (data_i.x[k] >>> Step);
        data_d.z[k] = data_i.z[k] - atan_q30(StepIdx);
      end else begin
        data_d.x[k] = data_i.x[k] + (data_i.y[k] >>> Step);
        data_d.y[k] = data_i.y[k] - (data_i.x[k] >>> Step);
        data_d.z[k] = data_i.z[k] + atan_q30(StepIdx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/epm_matrix.sv
// ----------------------------------------------------------------------------
// epm_matrix
// Builds the rotation entries from sines and cosines over five stages.
// ----------------------------------------------------------------------------
module epm_matrix import epm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cell_t data_i,
  output logic  valid_o,
  output pose_out_t data_o
);

  typedef logic signed [CsW-1:0] v_t;
  typedef logic signed [67:0]    p_t;

  function automatic v_t rnd(input p_t acc);
    p_t t;
    begin
      t = (acc + 68'sd536870912) >>> 30;
      if (t > 68'sd1073741824) return Q30One;
      else if (t < -68'sd1073741824) return -Q30One;
      else return v_t'(t);
    end
  endfunction

  // Stage 1: saturate and apply the quadrant flip.
  v_t s_d [3], c_d [3];
  v_t sa_q, ca_q, sp_q, cp_q, sr_q, cr_q;
  logic signed [31:0] px1_q, py1_q, pz1_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_d[k] = sat_unit(data_i.x[k]);
      s_d[k] = sat_unit(data_i.y[k]);
      if (data_i.flip[k]) begin
        c_d[k] = -c_d[k];
        s_d[k] = -s_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= s_d[0]; ca_q <= c_d[0];
      sp_q <= s_d[1]; cp_q <= c_d[1];
      sr_q <= s_d[2]; cr_q <= c_d[2];
      px1_q <= data_i.px; py1_q <= data_i.py; pz1_q <= data_i.pz;
    end
  end

  // Stage 2: single products.
  p_t sasp_q, casp_q, sacp_q, cpsr_q, cpcr_q, cacp_q;
  p_t cacr_q, casr_q, sacr_q, sasr_q;
  v_t sr2_q, cr2_q, sp2_q;
  logic signed [31:0] px2_q, py2_q, pz2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sasp_q <= 68'(sa_q * sp_q);
      casp_q <= 68'(ca_q * sp_q);
      sacp_q <= 68'(sa_q * cp_q);
      cpsr_q <= 68'(cp_q * sr_q);
      cpcr_q <= 68'(cp_q * cr_q);
      cacp_q <= 68'(ca_q * cp_q);
      cacr_q <= 68'(ca_q * cr_q);
      casr_q <= 68'(ca_q * sr_q);
      sacr_q <= 68'(sa_q * cr_q);
      sasr_q <= 68'(sa_q * sr_q);
      sr2_q <= sr_q; cr2_q <= cr_q; sp2_q <= sp_q;
      px2_q <= px1_q; py2_q <= py1_q; pz2_q <= pz1_q;
    end
  end

  // Stage 3: round the pair products and the single-product entries.
  v_t sasp_r_q, casp_r_q, r02_3_q, r10_3_q, r11_3_q, r22_3_q;
  p_t cacr3_q, casr3_q, sacr3_q, sasr3_q;
  v_t sr3_q, cr3_q, sp3_q;
  logic signed [31:0] px3_q, py3_q, pz3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sasp_r_q <= rnd(sasp_q);
      casp_r_q <= rnd(casp_q);
      r02_3_q  <= rnd(sacp_q);
      r10_3_q  <= rnd(cpsr_q);
      r11_3_q  <= rnd(cpcr_q);
      r22_3_q  <= rnd(cacp_q);
      cacr3_q <= cacr_q; casr3_q <= casr_q; sacr3_q <= sacr_q; sasr3_q <= sasr_q;
      sr3_q <= sr2_q; cr3_q <= cr2_q; sp3_q <= sp2_q;
      px3_q <= px2_q; py3_q <= py2_q; pz3_q <= pz2_q;
    end
  end

  // Stage 4: second products folded into the exact sums.
  p_t t00_q, t01_q, t20_q, t21_q;
  v_t r02_4_q, r10_4_q, r11_4_q, r22_4_q, sp4_q;
  logic signed [31:0] px4_q, py4_q, pz4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t00_q <= cacr3_q - 68'(sasp_r_q * sr3_q);
      t01_q <= -casr3_q - 68'(sasp_r_q * cr3_q);
      t20_q <= -sacr3_q - 68'(casp_r_q * sr3_q);
      t21_q <= sasr3_q - 68'(casp_r_q * cr3_q);
      r02_4_q <= r02_3_q; r10_4_q <= r10_3_q; r11_4_q <= r11_3_q; r22_4_q <= r22_3_q;
      sp4_q <= sp3_q;
      px4_q <= px3_q; py4_q <= py3_q; pz4_q <= pz3_q;
    end
  end

  // Stage 5: final rounding and output register.
  pose_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.rot_00  <= 32'(rnd(t00_q));
      out_q.rot_01  <= 32'(rnd(t01_q));
      out_q.rot_02  <= 32'(r02_4_q);
      out_q.rot_10  <= 32'(r10_4_q);
      out_q.rot_11  <= 32'(r11_4_q);
      out_q.rot_12  <= 32'(sp4_q);
      out_q.rot_20  <= 32'(rnd(t20_q));
      out_q.rot_21  <= 32'(rnd(t21_q));
      out_q.rot_22  <= 32'(r22_4_q);
      out_q.trans_x <= px4_q;
      out_q.trans_y <= py4_q;
      out_q.trans_z <= pz4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign data_o  = out_q;

endmodule

### sv/epm_checker.sv
// ----------------------------------------------------------------------------
// epm_checker
// Port-level checks of the pose block's transaction flow and of the rot_12 range.
// ----------------------------------------------------------------------------
`include "euler_pose_to_matrix_macros.svh"
module epm_checker import epm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input pose_out_t out_data_o
);

  `EPM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `EPM_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled while output empty")
  `EPM_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input taken while output stalled")
  `EPM_ASSERT_IMP(a_rot12_range, clk_i, rst_ni, out_valid_o, (out_data_o.rot_12 <= 32'sd1073741824) && (out_data_o.rot_12 >= -32'sd1073741824), "entry out of range")

endmodule

bind euler_pose_to_matrix epm_checker u_epm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
